### rtl/core/bwgco_pkg.sv
// Package for the bit-width group code optimizer.
// Holds default parameter values, fixed result field widths and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bwgco_pkg;

  // Default sizing of the block.
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_COUNT_BITS = 24;

  // Widths of the result fields.
  localparam int COUNT_OUT_BITS = 25;
  localparam int WIDTH_OUT_BITS = 6;
  localparam int COST_OUT_BITS  = 31;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_LOAD,    // taking items, one histogram update per cycle
    S_FLUSH,   // last histogram write lands, prefix table seeded
    S_PREFIX,  // sweep of the histogram into prefix sums
    S_DRAIN,   // wait for the cost pipeline to empty, then step the width or, at the widest, finish
    S_ISSUE,   // issue one table step per cycle for the current width
    S_DONE     // once the output is free, load the result register and clear the set state
  } bwgco_state_t;

endpackage : bwgco_pkg

`default_nettype wire

### rtl/core/bit_width_group_code_optimizer.sv
// Top level of the bit-width group code optimizer.
// Histogram loading, prefix-sum sweep and the grouping cost table walk in one module.
// Depends on bwgco_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                    Payload
// -------   --------------------------   ------------------------------------------------
// item      item_valid / item_ready      sample[31:0], last
// result    result_valid / result_ready  value_count, longest_width, best_cost, total_bits
//
// Items are taken one per clock while a set is loading: each item costs one histogram
// read-modify-write, with the write of the item before it forwarded. After the item marked
// last the block stops taking items while it sweeps the histogram into prefix sums and
// walks the cost table for each width up to the longest, then loads the result register.
// The cost table walk issues one table read per cycle and waits for its pipeline to empty
// at every width, since the next width reads what this one writes.
// Reset is synchronous and clears the histogram through its valid bits.
// A waiting result does not stall loading of the next set; only its final step waits.

module bit_width_group_code_optimizer #(
  parameter int VALUE_BITS = bwgco_pkg::DEF_VALUE_BITS,
  parameter int COUNT_BITS = bwgco_pkg::DEF_COUNT_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  item_valid,
  output logic                                 item_ready,
  input  wire  [31:0]                          sample,
  input  wire                                  last,
  output logic                                 result_valid,
  input  wire                                  result_ready,
  output logic [bwgco_pkg::COUNT_OUT_BITS-1:0] value_count,
  output logic [bwgco_pkg::WIDTH_OUT_BITS-1:0] longest_width,
  output logic [bwgco_pkg::COST_OUT_BITS-1:0]  best_cost,
  output logic [bwgco_pkg::COST_OUT_BITS-1:0]  total_bits
);

  import bwgco_pkg::*;

  // Widths are 1..VALUE_BITS; table rows and group counts stay below VALUE_BITS.
  localparam int W_BITS    = $clog2(VALUE_BITS + 1);
  localparam int T_BITS    = $clog2(VALUE_BITS);
  localparam int CNT_BITS  = COUNT_BITS + 1;
  localparam int SUM_BITS  = COUNT_BITS + T_BITS;
  localparam int WT_BITS   = W_BITS + 1;
  localparam int COST_BITS = SUM_BITS + WT_BITS;
  localparam int DP_DEPTH  = 1 << (2 * T_BITS);
  localparam int MAX_A     = (COST_BITS > CNT_BITS) ? COST_BITS : CNT_BITS;
  localparam int WIDE_BITS = ((MAX_A > COST_OUT_BITS) ? MAX_A : COST_OUT_BITS) + 1;

  localparam logic [WIDE_BITS-1:0] COST_CAP  = WIDE_BITS'({COST_OUT_BITS{1'b1}});
  localparam logic [WIDE_BITS-1:0] COUNT_CAP = WIDE_BITS'({COUNT_OUT_BITS{1'b1}});

  // Bookkeeping that travels with one cost table step down the pipeline.
  typedef struct packed {
    logic                  v;      // step present
    logic                  gz;     // no group before this one
    logic                  first;  // first split point of the group
    logic                  lastj;  // last split point of the group
    logic                  fin;    // group is the final one
    logic [WT_BITS-1:0]    wt;     // bits per value in this group
    logic [2*T_BITS-1:0]   waddr;  // table entry the group result goes to
  } dp_tag_t;

  // Bit length of the magnitude of the low VALUE_BITS bits, zero counting as one bit.
  // The most negative value negates to itself, which is already its magnitude.
  function automatic logic [W_BITS-1:0] mag_width(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] mag;
    logic [W_BITS-1:0]     wd;
    mag = v[VALUE_BITS-1] ? VALUE_BITS'(~v + 1'b1) : v;
    wd  = W_BITS'(1);
    for (int b = 1; b < VALUE_BITS; b++) begin
      if (mag[b]) wd = W_BITS'(b + 1);
    end
    return wd;
  endfunction

  bwgco_state_t state, state_next;

  // Control decoded from the state.
  logic item_acc, iss, pfx_rd, pm_init, out_free, fin_load, pipe_empty;

  // Set state.
  logic [CNT_BITS-1:0]   loaded_count;
  logic [W_BITS-1:0]     widest;
  logic [VALUE_BITS-1:0] hist_vld;

  // Histogram memory and its load stage.
  logic [COUNT_BITS-1:0] hist_mem [VALUE_BITS];
  logic [COUNT_BITS-1:0] hist_q;
  logic [T_BITS-1:0]     hist_raddr;
  logic [W_BITS-1:0]     in_w;
  logic [T_BITS-1:0]     in_bin;
  logic                  l_v;
  logic [T_BITS-1:0]     l_bin;
  logic [W_BITS-1:0]     l_w;
  logic [COUNT_BITS-1:0] l_cur, l_new;
  logic                  wb_v;
  logic [T_BITS-1:0]     wb_bin;
  logic [COUNT_BITS-1:0] wb_data;

  // Prefix sweep.
  logic [T_BITS-1:0]     pidx;
  logic                  p_v;
  logic [T_BITS-1:0]     p_bin;
  logic [SUM_BITS-1:0]   psum, psum_new;

  // Prefix memory: entry i holds the count of values with width at most i.
  logic [SUM_BITS-1:0]   pfx_mem [VALUE_BITS+1];
  logic                  pm_we;
  logic [W_BITS-1:0]     pm_waddr;
  logic [SUM_BITS-1:0]   pm_wdata;
  logic [SUM_BITS-1:0]   pj_q, pw_q;

  // Cost table: entry {w, g} is the least cost of widths 1..w in g groups, none final.
  logic [COST_BITS-1:0]  dp_mem [DP_DEPTH];
  logic [COST_BITS-1:0]  dq;
  logic                  dp_we;

  // Table walk counters.
  logic [W_BITS-1:0]     w;
  logic [T_BITS-1:0]     g, j;
  logic                  iss_lastj, iss_end, iss_fin;

  // Cost pipeline.
  dp_tag_t               s1, s2, s3, s4, s4_next;
  logic [SUM_BITS-1:0]   s2_diff;
  logic [COST_BITS-1:0]  s2_base, s3_base, s3_prod;
  logic [COST_BITS-1:0]  cand, acc, acc_new, s4_cost, best;

  logic [WIDE_BITS-1:0]  best_w, cnt_w, tot_w;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign pipe_empty = !(s1.v || s2.v || s3.v || s4.v || p_v);
  assign out_free   = !result_valid || result_ready;
  assign iss_lastj  = (g == '0) || (W_BITS'(j) == w - 1'b1);
  assign iss_end    = iss_lastj && (W_BITS'(g) == w - 1'b1);
  assign iss_fin    = (w == widest);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:   if (item_acc && last) state_next = S_FLUSH;
      S_FLUSH:  state_next = S_PREFIX;
      S_PREFIX: if (pidx == T_BITS'(VALUE_BITS - 1)) state_next = S_DRAIN;
      S_DRAIN:  if (pipe_empty) state_next = (w == widest) ? S_DONE : S_ISSUE;
      S_ISSUE:  if (iss_end) state_next = S_DRAIN;
      S_DONE:   if (out_free) state_next = S_LOAD;
      default:  state_next = S_LOAD;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    pfx_rd     = 1'b0;
    pm_init    = 1'b0;
    iss        = 1'b0;
    fin_load   = 1'b0;
    unique case (state)
      S_LOAD:   item_ready = 1'b1;
      S_FLUSH:  pm_init    = 1'b1;
      S_PREFIX: pfx_rd     = 1'b1;
      S_DRAIN:  ;
      S_ISSUE:  iss        = 1'b1;
      S_DONE:   fin_load   = out_free;
      default:  ;
    endcase
  end

  assign item_acc = item_valid && item_ready;

  // ---------------------------------------------------------------------------
  // Histogram loading
  // ---------------------------------------------------------------------------
  assign in_w       = mag_width(sample[VALUE_BITS-1:0]);
  assign in_bin     = T_BITS'(in_w - 1'b1);
  assign hist_raddr = pfx_rd ? pidx : in_bin;

  // The write of the item just before lands on the same edge as this read, so it is
  // taken from the write-back register instead. A bin not written in this set reads zero.
  always_comb begin
    if (wb_v && (wb_bin == l_bin)) begin
      l_cur = wb_data;
    end else begin
      l_cur = hist_vld[l_bin] ? hist_q : '0;
    end
    l_new = (&l_cur) ? l_cur : l_cur + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (l_v) hist_mem[l_bin] <= l_new;
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l_v          <= 1'b0;
      wb_v         <= 1'b0;
      hist_vld     <= '0;
      loaded_count <= '0;
      widest       <= '0;
    end else begin
      l_v  <= item_acc;
      wb_v <= l_v;
      if (fin_load) begin
        hist_vld     <= '0;
        loaded_count <= '0;
        widest       <= '0;
      end else if (l_v) begin
        hist_vld[l_bin] <= 1'b1;
        if (!(&loaded_count)) loaded_count <= loaded_count + 1'b1;
        if (l_w > widest) widest <= l_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    l_bin   <= in_bin;
    l_w     <= in_w;
    wb_bin  <= l_bin;
    wb_data <= l_new;
  end

  // ---------------------------------------------------------------------------
  // Prefix sums
  // ---------------------------------------------------------------------------
  assign psum_new = psum + SUM_BITS'(hist_vld[p_bin] ? hist_q : '0);

  always_comb begin
    pm_we    = pm_init || p_v;
    pm_waddr = pm_init ? '0 : W_BITS'(p_bin) + 1'b1;
    pm_wdata = pm_init ? '0 : psum_new;
  end

  always_ff @(posedge clk) begin
    if (pm_we) pfx_mem[pm_waddr] <= pm_wdata;
    pj_q <= pfx_mem[W_BITS'(j)];
    pw_q <= pfx_mem[w];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else begin
      p_v <= pfx_rd;
    end
  end

  always_ff @(posedge clk) begin
    p_bin <= pidx;
    if (pm_init) begin
      psum <= '0;
      pidx <= '0;
    end else begin
      if (p_v) psum <= psum_new;
      if (pfx_rd) pidx <= pidx + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Cost table walk: width w, groups before g, previous split point j
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (pm_init) begin
      w <= '0;
    end else if (state == S_DRAIN && pipe_empty && !iss_fin) begin
      w <= w + 1'b1;
      g <= '0;
      j <= '0;
    end else if (iss) begin
      if (iss_lastj) begin
        g <= g + 1'b1;
        j <= g + 1'b1;
      end else begin
        j <= j + 1'b1;
      end
    end
  end

  assign dp_we = s4.v && !s4.fin;

  always_ff @(posedge clk) begin
    if (dp_we) dp_mem[s4.waddr] <= s4_cost;
    dq <= dp_mem[{j, g}];
  end

  // Group cost: values with widths above the split point and up to w, times the bits
  // each one takes. The first group starts from the empty cover, which costs nothing.
  assign cand    = s3_base + s3_prod;
  assign acc_new = (s3.first || (cand < acc)) ? cand : acc;

  // Only the step at the last split point of a group carries a finished group cost.
  always_comb begin
    s4_next   = s3;
    s4_next.v = s3.v && s3.lastj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
    end else begin
      s1.v     <= iss;
      s1.gz    <= (g == '0);
      s1.first <= (j == g);
      s1.lastj <= iss_lastj;
      s1.fin   <= iss_fin;
      s1.wt    <= WT_BITS'(w) + WT_BITS'(g) + WT_BITS'(!iss_fin);
      s1.waddr <= {T_BITS'(w), g + 1'b1};
      s2       <= s1;
      s3       <= s2;
      s4       <= s4_next;
    end
  end

  always_ff @(posedge clk) begin
    s2_diff <= pw_q - pj_q;
    s2_base <= s1.gz ? '0 : dq;
    s3_prod <= COST_BITS'(s2_diff) * COST_BITS'(s2.wt);
    s3_base <= s2_base;
    if (s3.v) acc <= acc_new;
    s4_cost <= acc_new;
    if (s4.v && s4.fin && (s4.gz || (s4_cost < best))) best <= s4_cost;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  assign best_w = WIDE_BITS'(best);
  assign cnt_w  = WIDE_BITS'(loaded_count);
  assign tot_w  = best_w + cnt_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      value_count   <= (cnt_w > COUNT_CAP) ? '1 : COUNT_OUT_BITS'(cnt_w);
      longest_width <= WIDTH_OUT_BITS'(widest);
      best_cost     <= (best_w > COST_CAP) ? '1 : COST_OUT_BITS'(best_w);
      total_bits    <= (tot_w > COST_CAP) ? '1 : COST_OUT_BITS'(tot_w);
    end
  end

endmodule : bit_width_group_code_optimizer

`default_nettype wire
